[rtl/record_table_insertion_sort_defines.svh]
// Assertion macros used by the record table sequencer.
`ifndef RECORD_TABLE_INSERTION_SORT_DEFINES_SVH
`define RECORD_TABLE_INSERTION_SORT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("record table: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("record table: next-cycle check failed");

`endif

[rtl/rts_pkg.sv]
package rts_pkg;

	// Table geometry.
	localparam int DEPTH = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Operation codes.
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_SORT   = 1'b1;

	// Sex codes that are accepted.
	localparam logic [1:0] SEX_MALE   = 2'd0;
	localparam logic [1:0] SEX_FEMALE = 2'd1;

	// Result status codes.
	localparam logic [2:0] ST_APPENDED = 3'd0;
	localparam logic [2:0] ST_BAD_SEX  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_SORTED   = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	// One stored record; the tag sits in the lowest bits.
	typedef struct packed {
		logic signed [13:0] death;
		logic signed [13:0] birth;
		logic [11:0]        tag;
	} rec_t;

	// One input word after unpacking.
	typedef struct packed {
		logic       opcode;
		logic       key_select;
		logic [1:0] sex_code;
		rec_t       rec;
	} item_t;

	// One result offered to the output register.
	typedef struct packed {
		logic       valid;
		rec_t       rec;
		logic [2:0] status;
		logic       last;
	} res_t;

	// Access to the record store: one write and one registered read per cycle.
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		rec_t             wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

	// Sort key of a record.
	function automatic logic signed [13:0] key_of(rec_t r, logic sel);
		return sel ? r.death : r.birth;
	endfunction

endpackage

[rtl/record_table_insertion_sort.sv]
// Record table with stable insertion sort.
// Input words arrive on the s_ group: tuser carries the operation and sort key select,
// tdata the record fields. Append words store one record and give one result word with
// the status; a sort word reorders the table in place by birth or death year and then
// sends every record in order on the m_ group, tuser holding the status, tlast the end.
// A sort of an empty table gives one word with the empty status.
// An append or refused item passes to the response state, which offers its result word
// to the output register; the block takes the next item once that word has been loaded.
// A sort of N records fetches and holds the record at each outer index, compares its key
// with one lower entry at a time (at most N*(N-1)/2 compares), writes it at the head when
// it moves there, then reads and emits every record in turn.
// Sort speed is set by the single compare unit and the one-read, one-write record store.
// s_tready is high only while the sequencer is idle; one item is in work at a time.
// A stall on m_tready holds the output register and the sequencer waits; nothing is lost.
// Reset clears the fill count and returns the sequencer to idle; the stored records
// themselves are not cleared and become unreachable.
module record_table_insertion_sort (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // record_tag, birth_year, death_year, sex_code, zero fill
	input  logic [1:0]  s_tuser,   // opcode, key_select
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // out_tag, out_birth, out_death
	output logic [2:0]  m_tuser,   // status
	output logic        m_tlast
);

	rts_pkg::item_t    item;
	rts_pkg::res_t     res;
	rts_pkg::mem_req_t mem_req;
	rts_pkg::rec_t     rd_data;
	logic              res_ready;
	logic              out_valid_q;
	rts_pkg::rec_t     out_rec_q;
	logic [2:0]        out_status_q;
	logic              out_last_q;

	// Unpack the input word.
	always_comb begin
		item.opcode     = s_tuser[0];
		item.key_select = s_tuser[1];
		item.rec        = rts_pkg::rec_t'(s_tdata[39:0]);
		item.sex_code   = s_tdata[41:40];
	end

	rts_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.res       (res),
		.res_ready (res_ready),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	rts_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// Output register: loads when empty or when its word is being taken.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_rec_q    <= res.rec;
			out_status_q <= res.status;
			out_last_q   <= res.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_rec_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

[rtl/rts_store.sv]
module rts_store (
	input  logic              clk,
	input  rts_pkg::mem_req_t req,
	output rts_pkg::rec_t     rd_data
);

	rts_pkg::rec_t mem_q [rts_pkg::DEPTH];
	rts_pkg::rec_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/rts_seq.sv]
`include "record_table_insertion_sort_defines.svh"

module rts_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rts_pkg::item_t    item,
	output rts_pkg::res_t     res,
	input  logic              res_ready,
	output rts_pkg::mem_req_t mem_req,
	input  rts_pkg::rec_t     rd_data
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_RESP    = 8'b0000_0010,
		S_FETCH   = 8'b0000_0100,
		S_HOLD    = 8'b0000_1000,
		S_CMP     = 8'b0001_0000,
		S_PLACE   = 8'b0010_0000,
		S_EMIT_RD = 8'b0100_0000,
		S_EMIT    = 8'b1000_0000
	} state_t;

	state_t                      state_q, state_d;
	logic [rts_pkg::CNT_W-1:0]   count_q, count_d;
	logic [rts_pkg::IDX_W-1:0]   i_q, i_d;
	logic [rts_pkg::IDX_W-1:0]   j_q, j_d;
	logic [rts_pkg::IDX_W-1:0]   k_q, k_d;
	logic                        sel_q, sel_d;
	logic [2:0]                  st_q, st_d;
	rts_pkg::rec_t               x_q, x_d;
	logic                        accept;
	logic                        x_less;
	logic                        i_done;
	logic                        emit_last;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Single compare: held record against the entry just read.
	assign x_less = rts_pkg::key_of(x_q, sel_q) < rts_pkg::key_of(rd_data, sel_q);

	// Outer pass finished when the next index reaches the fill count.
	assign i_done    = (rts_pkg::CNT_W'(i_q) + rts_pkg::CNT_W'(1)) == count_q;
	assign emit_last = (rts_pkg::CNT_W'(k_q) + rts_pkg::CNT_W'(1)) == count_q;

	// Sequencer.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		sel_d   = sel_q;
		st_d    = st_q;
		x_d     = x_q;
		mem_req = '0;
		res     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.opcode == rts_pkg::OP_APPEND) begin
						state_d = S_RESP;
						if (item.sex_code != rts_pkg::SEX_MALE &&
							item.sex_code != rts_pkg::SEX_FEMALE) begin
							st_d = rts_pkg::ST_BAD_SEX;
						end else if (count_q == rts_pkg::CNT_W'(rts_pkg::DEPTH)) begin
							st_d = rts_pkg::ST_FULL;
						end else begin
							mem_req.wr_en   = 1'b1;
							mem_req.wr_addr = count_q[rts_pkg::IDX_W-1:0];
							mem_req.wr_data = item.rec;
							count_d         = count_q + rts_pkg::CNT_W'(1);
							st_d            = rts_pkg::ST_APPENDED;
						end
					end else begin
						sel_d = item.key_select;
						if (count_q == '0) begin
							st_d    = rts_pkg::ST_EMPTY;
							state_d = S_RESP;
						end else if (count_q == rts_pkg::CNT_W'(1)) begin
							k_d     = '0;
							state_d = S_EMIT_RD;
						end else begin
							i_d     = rts_pkg::IDX_W'(1);
							state_d = S_FETCH;
						end
					end
				end
			end
			S_RESP: begin
				res.valid  = 1'b1;
				res.status = st_q;
				res.last   = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = i_q;
				j_d             = i_q;
				state_d         = S_HOLD;
			end
			S_HOLD: begin
				x_d             = rd_data;
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = j_q - rts_pkg::IDX_W'(1);
				state_d         = S_CMP;
			end
			S_CMP: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = j_q;
				if (x_less) begin
					// Shift the larger entry up and look one place lower.
					mem_req.wr_data = rd_data;
					j_d             = j_q - rts_pkg::IDX_W'(1);
					if (j_q == rts_pkg::IDX_W'(1)) begin
						state_d = S_PLACE;
					end else begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = j_q - rts_pkg::IDX_W'(1) - rts_pkg::IDX_W'(1);
					end
				end else begin
					mem_req.wr_data = x_q;
					if (i_done) begin
						k_d     = '0;
						state_d = S_EMIT_RD;
					end else begin
						i_d     = i_q + rts_pkg::IDX_W'(1);
						state_d = S_FETCH;
					end
				end
			end
			S_PLACE: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = j_q;
				mem_req.wr_data = x_q;
				if (i_done) begin
					k_d     = '0;
					state_d = S_EMIT_RD;
				end else begin
					i_d     = i_q + rts_pkg::IDX_W'(1);
					state_d = S_FETCH;
				end
			end
			S_EMIT_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = k_q;
				state_d         = S_EMIT;
			end
			S_EMIT: begin
				res.valid  = 1'b1;
				res.rec    = rd_data;
				res.status = rts_pkg::ST_SORTED;
				res.last   = emit_last;
				if (res_ready) begin
					if (emit_last) begin
						state_d = S_IDLE;
					end else begin
						k_d     = k_q + rts_pkg::IDX_W'(1);
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			sel_q   <= 1'b0;
			st_q    <= rts_pkg::ST_APPENDED;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			sel_q   <= sel_d;
			st_q    <= st_d;
		end
	end

	// Record held during one insertion pass.
	always_ff @(posedge clk) begin
		x_q <= x_d;
	end

	`RTS_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= rts_pkg::CNT_W'(rts_pkg::DEPTH))
	`RTS_ASSERT_IMPL(a_res_source, clk, arst_n, res.valid, state_q == S_RESP || state_q == S_EMIT)
	`RTS_ASSERT_IMPL(a_cmp_above_zero, clk, arst_n, state_q == S_CMP, j_q != '0)
	`RTS_ASSERT_IMPL(a_sort_keeps_count, clk, arst_n, state_q != S_IDLE, count_d == count_q)
	`RTS_ASSERT_NEXT(a_last_to_idle, clk, arst_n, res.valid && res_ready && res.last, state_q == S_IDLE)

endmodule
